@@ design/hce_pkg.sv @@
// ----------------------------------------------------------------------------
// hce_pkg: Hill cipher encryption constants
// Alphabet, padding letter and the constants of the shared multiply-accumulate
// and modulo-26 reduction datapath.
// ----------------------------------------------------------------------------
package hce_pkg;

	localparam int MAX_BLOCK_DFLT = 8;

	localparam int LTR_W = 5;
	localparam int KEY_W = 30;
	localparam int CFG_W = 4;

	localparam int ALPHABET = 26;
	localparam logic [LTR_W-1:0] PAD_LETTER = 5'd23;

	// key value split into 10-bit chunks; weight of chunk k is 2^(10k) mod 26
	localparam int CHUNK_W   = 10;
	localparam int KEY_STEPS = 3;
	localparam logic [LTR_W-1:0] KEY_WT0 = 5'd1;
	localparam logic [LTR_W-1:0] KEY_WT1 = 5'd10;
	localparam logic [LTR_W-1:0] KEY_WT2 = 5'd22;

	// accumulator covers 3 weighted key chunks and up to 16 letter products
	localparam int ACC_W = 16;

	// floor(acc / 26) ~= (acc * RECIP_M) >> RECIP_S, low by at most one
	localparam int RECIP_W = 16;
	localparam int RECIP_S = 20;
	localparam logic [RECIP_W-1:0] RECIP_M = 16'd40329;
	localparam int QUO_W = ACC_W + RECIP_W - RECIP_S;

endpackage

@@ design/hce_ram.sv @@
// ----------------------------------------------------------------------------
// hce_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/hill_cipher_encrypt.sv @@
// ----------------------------------------------------------------------------
// hill_cipher_encrypt: Hill cipher encryption over A..Z
// Key entries load into a key RAM reduced mod 26; letters gather into blocks
// of n and each full block is multiplied by the key mod 26.
// ----------------------------------------------------------------------------
// A letter beat that does not complete its block is accepted into the block buffer
// and in_ready stays high. A completing letter (full block, or last_letter set,
// which pads with X) starts n rows of n multiply-accumulates on one shared
// 10x5 multiplier fed by the key RAM's single read port: each row runs
// n key reads, one drain step and the two-step mod-26 reduction, and in_ready
// stays low until the block's last cipher letter is loaded. A key-load beat
// runs three weighted 10-bit chunks, then the same reduction.
// Each cipher letter sits in an output register, so row i+1 runs while row i
// waits to be taken. A block_size write drops any partial block.
// ----------------------------------------------------------------------------
module hill_cipher_encrypt import hce_pkg::*; #(
	parameter int MAX_BLOCK = MAX_BLOCK_DFLT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  logic [2:0]       key_row,
	input  logic [2:0]       key_col,
	input  logic [KEY_W-1:0] key_value,
	input  logic [LTR_W-1:0] letter,
	input  logic             last_letter,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [LTR_W-1:0] cipher_letter,
	output logic             last_of_block
);

	localparam int DEPTH = MAX_BLOCK * MAX_BLOCK;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int NW    = $clog2(MAX_BLOCK + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_KEY,
		S_ROW,
		S_TAIL,
		S_RED1,
		S_RED2
	} state_t;

	function automatic logic [NW-1:0] clamp_n(input logic [CFG_W-1:0] v);
		logic [NW-1:0] r;
		if (v == '0) begin
			r = NW'(1);
		end else if (int'(v) > MAX_BLOCK) begin
			r = NW'(MAX_BLOCK);
		end else begin
			r = NW'(v);
		end
		return r;
	endfunction

	state_t            state_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     fill_q;
	logic              mode_q;
	logic [1:0]        k_q;
	logic [IW-1:0]     h_q;
	logic [IW-1:0]     hd_q;
	logic [IW-1:0]     i_q;
	logic [AW-1:0]     row_base_q;
	logic              out_valid_q;
	logic [LTR_W-1:0]  cipher_q;
	logic              last_q;

	logic [LTR_W-1:0]  buf_q [MAX_BLOCK];
	logic [KEY_W-1:0]  kv_q;
	logic [AW-1:0]     kaddr_q;
	logic [ACC_W-1:0]  acc_q;
	logic [QUO_W-1:0]  q_q;

	logic              in_fire;
	logic              key_ok;
	logic [AW-1:0]     key_addr;
	logic [LTR_W-1:0]  letter_red;
	logic [NW-1:0]     fill_idx;
	logic [NW-1:0]     fill_nxt;
	logic              blk_full;
	logic              last_h;
	logic              last_row;
	logic              out_free;
	logic              out_load;
	logic              red_go;

	logic [AW-1:0]     ram_raddr;
	logic [LTR_W-1:0]  ram_rdata;
	logic              ram_we;

	logic [CHUNK_W-1:0]       mul_a;
	logic [LTR_W-1:0]         mul_b;
	logic [CHUNK_W+LTR_W-1:0] prod;
	logic [ACC_W-1:0]         acc_nxt;

	logic [ACC_W+RECIP_W-1:0] recip_p;
	logic [ACC_W-1:0]         qx26;
	logic [ACC_W-1:0]         diff;
	logic [5:0]               r6;
	logic [LTR_W-1:0]         red_res;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	assign key_ok   = (int'(key_row) < MAX_BLOCK) && (int'(key_col) < MAX_BLOCK);
	assign key_addr = AW'(int'(key_row) * MAX_BLOCK + int'(key_col));

	assign letter_red = (letter >= LTR_W'(ALPHABET)) ? letter - LTR_W'(ALPHABET) : letter;
	assign fill_idx   = (fill_q >= n_q) ? '0 : fill_q;
	assign fill_nxt   = last_letter ? n_q : fill_idx + NW'(1);
	assign blk_full   = (fill_nxt == n_q);

	assign last_h   = (NW'(h_q) + NW'(1)) == n_q;
	assign last_row = (NW'(i_q) + NW'(1)) == n_q;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_RED2) && mode_q && out_free;
	assign red_go   = !mode_q || out_free;

	// shared multiplier: weighted key chunks or key entry times letter
	always_comb begin
		mul_a = {{(CHUNK_W-LTR_W){1'b0}}, ram_rdata};
		mul_b = buf_q[hd_q];
		if (state_q == S_KEY) begin
			case (k_q)
				2'd0: begin
					mul_a = kv_q[CHUNK_W-1:0];
					mul_b = KEY_WT0;
				end
				2'd1: begin
					mul_a = kv_q[2*CHUNK_W-1:CHUNK_W];
					mul_b = KEY_WT1;
				end
				default: begin
					mul_a = kv_q[3*CHUNK_W-1:2*CHUNK_W];
					mul_b = KEY_WT2;
				end
			endcase
		end
	end

	assign prod    = mul_a * mul_b;
	assign acc_nxt = acc_q + ACC_W'(prod);

	// mod 26: reciprocal estimate, then one correction
	assign recip_p = acc_q * RECIP_M;
	assign qx26    = ACC_W'(q_q * ALPHABET);
	assign diff    = acc_q - qx26;
	assign r6      = diff[5:0];
	assign red_res = (r6 >= 6'(ALPHABET)) ? LTR_W'(r6 - 6'(ALPHABET)) : r6[LTR_W-1:0];

	assign ram_raddr = row_base_q + AW'(h_q);
	assign ram_we    = (state_q == S_RED2) && !mode_q;

	hce_ram #(
		.WIDTH (LTR_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (kaddr_q),
		.wdata (red_res),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= clamp_n(CFG_W'(2));
			fill_q      <= '0;
			mode_q      <= 1'b0;
			k_q         <= '0;
			h_q         <= '0;
			i_q         <= '0;
			row_base_q  <= '0;
			out_valid_q <= 1'b0;
			cipher_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						mode_q <= action;
						if (!action) begin
							k_q <= '0;
							if (key_ok) begin
								state_q <= S_KEY;
							end
						end else if (blk_full) begin
							i_q        <= '0;
							h_q        <= '0;
							row_base_q <= '0;
							state_q    <= S_ROW;
						end
					end
				end
				S_KEY: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'(KEY_STEPS - 1)) begin
						state_q <= S_RED1;
					end
				end
				S_ROW: begin
					if (last_h) begin
						state_q <= S_TAIL;
					end else begin
						h_q <= h_q + IW'(1);
					end
				end
				S_TAIL: begin
					state_q <= S_RED1;
				end
				S_RED1: begin
					state_q <= S_RED2;
				end
				S_RED2: begin
					if (!mode_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						cipher_q <= red_res;
						last_q   <= last_row;
						if (last_row) begin
							state_q <= S_IDLE;
						end else begin
							i_q        <= i_q + IW'(1);
							h_q        <= '0;
							row_base_q <= row_base_q + AW'(MAX_BLOCK);
							state_q    <= S_ROW;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				n_q    <= clamp_n(cfg_data);
				fill_q <= '0;
			end else if (in_fire && action) begin
				fill_q <= blk_full ? '0 : fill_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				acc_q <= '0;
				if (in_fire) begin
					if (!action) begin
						kv_q    <= key_value;
						kaddr_q <= key_addr;
					end else begin
						for (int j = 0; j < MAX_BLOCK; j++) begin
							if (NW'(j) == fill_idx) begin
								buf_q[j] <= letter_red;
							end else if (last_letter && NW'(j) > fill_idx && NW'(j) < n_q) begin
								buf_q[j] <= PAD_LETTER;
							end
						end
					end
				end
			end
			S_KEY: begin
				acc_q <= acc_nxt;
			end
			S_ROW: begin
				hd_q <= h_q;
				if (h_q != '0) begin
					acc_q <= acc_nxt;
				end
			end
			S_TAIL: begin
				acc_q <= acc_nxt;
			end
			S_RED1: begin
				q_q <= recip_p[ACC_W+RECIP_W-1:RECIP_S];
			end
			S_RED2: begin
				if (red_go) begin
					acc_q <= '0;
				end
			end
			default: begin
				acc_q <= '0;
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign cipher_letter = cipher_q;
	assign last_of_block = last_q;

endmodule
